FILE: design/sorted_wakeup_timer_queue_assert.svh
// Assertion macros used by the sorted wakeup timer queue datapath.
`ifndef SORTED_WAKEUP_TIMER_QUEUE_ASSERT_SVH
`define SORTED_WAKEUP_TIMER_QUEUE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SWTQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorted wakeup timer queue: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define SWTQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorted wakeup timer queue: next-cycle check failed");

`endif

FILE: design/swtq_pkg.sv
// Types, codes and constants shared by the sorted wakeup timer queue modules.
package swtq_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int TPS_W = 30;
  localparam logic [TPS_W-1:0] TPS_RESET = 30'd1000000;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_WAKE   = 1'b1;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_QUEUED   = 2'd1;
  localparam logic [1:0] ST_NEGATIVE = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic               req_type;
    logic [15:0]        requester_id;
    logic signed [31:0] sleep_seconds;
    logic [63:0]        now_time;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [1:0]  status;
    logic [15:0] woken_id;
    logic        last;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       cap;
    logic       mul;
    logic       ins_init;
    logic       add;
    logic       rd_head;
    logic       rd_prev;
    logic       wr_shift;
    logic       wr_new;
    logic       pop;
    logic       emit;
    logic       emit_kind;
    logic [1:0] emit_status;
    logic       emit_last;
    logic       emit_pend;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_tick;
    logic is_neg;
    logic is_zero;
    logic full;
    logic empty;
    logic last_entry;
    logic k_zero;
    logic rd_later;
    logic rd_due;
  } dp_status_t;

endpackage

FILE: design/swtq_ctrl.sv
// Controller state machine of the sorted wakeup timer queue.
module swtq_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  swtq_pkg::dp_status_t sts,
  output swtq_pkg::ctrl_cmd_t  cmd
);
  import swtq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_MUL, S_ADD, S_INS_CHK, S_INS_CMP, S_T_RD, S_T_CMP, S_T_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   pend_r, pend_nxt;

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    pend_nxt  = pend_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.cap   = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        pend_nxt = 1'b0;
        if (sts.is_tick) begin
          state_nxt = sts.empty ? S_IDLE : S_T_RD;
        end else if (sts.is_neg || sts.is_zero || sts.full) begin
          cmd.emit        = 1'b1;
          cmd.emit_kind   = KIND_STATUS;
          cmd.emit_last   = 1'b1;
          cmd.emit_status = sts.is_neg ? ST_NEGATIVE : (sts.is_zero ? ST_DONE : ST_FULL);
          state_nxt       = S_IDLE;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul      = 1'b1;
        cmd.ins_init = 1'b1;
        state_nxt    = S_ADD;
      end
      S_ADD: begin
        cmd.add   = 1'b1;
        state_nxt = S_INS_CHK;
      end
      S_INS_CHK: begin
        if (sts.k_zero) begin
          cmd.wr_new      = 1'b1;
          cmd.emit        = 1'b1;
          cmd.emit_kind   = KIND_STATUS;
          cmd.emit_status = ST_QUEUED;
          cmd.emit_last   = 1'b1;
          state_nxt       = S_IDLE;
        end else begin
          cmd.rd_prev = 1'b1;
          state_nxt   = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        if (sts.rd_later) begin
          cmd.wr_shift = 1'b1;
          state_nxt    = S_INS_CHK;
        end else begin
          cmd.wr_new      = 1'b1;
          cmd.emit        = 1'b1;
          cmd.emit_kind   = KIND_STATUS;
          cmd.emit_status = ST_QUEUED;
          cmd.emit_last   = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      S_T_RD: begin
        cmd.rd_head = 1'b1;
        state_nxt   = S_T_CMP;
      end
      S_T_CMP: begin
        cmd.emit_kind   = KIND_WAKE;
        cmd.emit_status = ST_DONE;
        cmd.emit_pend   = 1'b1;
        if (sts.rd_due) begin
          cmd.emit      = pend_r;
          cmd.emit_last = 1'b0;
          cmd.pop       = 1'b1;
          pend_nxt      = 1'b1;
          state_nxt     = sts.last_entry ? S_T_FIN : S_T_RD;
        end else begin
          cmd.emit      = pend_r;
          cmd.emit_last = 1'b1;
          pend_nxt      = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      S_T_FIN: begin
        cmd.emit        = 1'b1;
        cmd.emit_kind   = KIND_WAKE;
        cmd.emit_status = ST_DONE;
        cmd.emit_pend   = 1'b1;
        cmd.emit_last   = 1'b1;
        pend_nxt        = 1'b0;
        state_nxt       = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
    end
  end

endmodule

FILE: design/swtq_datapath.sv
// Datapath of the sorted wakeup timer queue: request registers, deadline math and the store.
`include "sorted_wakeup_timer_queue_assert.svh"
module swtq_datapath #(
  parameter int DEPTH = swtq_pkg::DEPTH_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  swtq_pkg::in_item_t          in_data,
  input  logic [swtq_pkg::TPS_W-1:0]  ticks_per_second,
  input  swtq_pkg::ctrl_cmd_t         cmd,
  output swtq_pkg::dp_status_t        sts,
  output logic                        out_strobe,
  output swtq_pkg::out_item_t         out_data
);
  import swtq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int DLY_W = 31 + TPS_W;

  // Captured request.
  logic               type_r;
  logic [15:0]        id_r;
  logic [31:0]        sec_r;
  logic [63:0]        now_r;
  logic [DLY_W-1:0]   delay_r;
  logic [63:0]        deadline_r;

  // Queue bookkeeping: circular buffer with head pointer.
  logic [AW-1:0]      head_r, head_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [AW-1:0]      p_r;
  logic [CW-1:0]      k_r;
  logic [15:0]        pend_id_r;

  logic [63:0]        mem_dl [DEPTH];
  logic [15:0]        mem_id [DEPTH];
  logic [63:0]        rd_dl_r;
  logic [15:0]        rd_id_r;

  logic [AW-1:0]      p_prev, head_next, rd_addr, tail;
  logic [CW:0]        tail_sum;
  logic [64:0]        dl_sum;
  logic               out_valid_r;
  out_item_t          out_r;

  assign p_prev    = (p_r == '0) ? AW'(DEPTH - 1) : p_r - 1'b1;
  assign head_next = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign rd_addr   = cmd.rd_head ? head_r : p_prev;
  assign tail_sum  = (CW+1)'(head_r) + (CW+1)'(count_r);
  always_comb begin
    if (tail_sum >= (CW+1)'(DEPTH)) tail = AW'(tail_sum - (CW+1)'(DEPTH));
    else                            tail = AW'(tail_sum);
  end
  assign dl_sum = {1'b0, now_r} + 65'(delay_r);

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      type_r <= in_data.req_type;
      id_r   <= in_data.requester_id;
      sec_r  <= in_data.sleep_seconds;
      now_r  <= in_data.now_time;
    end
    if (cmd.mul) delay_r <= DLY_W'(sec_r[30:0]) * DLY_W'(ticks_per_second);
    if (cmd.add) deadline_r <= dl_sum[64] ? '1 : dl_sum[63:0];
    if (cmd.ins_init) begin
      p_r <= tail;
      k_r <= count_r;
    end else if (cmd.wr_shift) begin
      p_r <= p_prev;
      k_r <= k_r - 1'b1;
    end
    if (cmd.pop) pend_id_r <= rd_id_r;
  end

  // Store: one write port at the insertion pointer, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.wr_shift) begin
      mem_dl[p_r] <= rd_dl_r;
      mem_id[p_r] <= rd_id_r;
    end else if (cmd.wr_new) begin
      mem_dl[p_r] <= deadline_r;
      mem_id[p_r] <= id_r;
    end
    if (cmd.rd_head || cmd.rd_prev) begin
      rd_dl_r <= mem_dl[rd_addr];
      rd_id_r <= mem_id[rd_addr];
    end
  end

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    if (cmd.wr_new) count_nxt = count_r + 1'b1;
    if (cmd.pop) begin
      count_nxt = count_r - 1'b1;
      head_nxt  = head_next;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r.result_kind <= cmd.emit_kind;
      out_r.status      <= cmd.emit_status;
      out_r.woken_id    <= cmd.emit_pend ? pend_id_r : id_r;
      out_r.last        <= cmd.emit_last;
    end
  end

  assign out_strobe = out_valid_r;
  assign out_data   = out_r;

  assign sts.is_tick    = type_r;
  assign sts.is_neg     = sec_r[31];
  assign sts.is_zero    = (sec_r == '0);
  assign sts.full       = (count_r == CW'(DEPTH));
  assign sts.empty      = (count_r == '0);
  assign sts.last_entry = (count_r == CW'(1));
  assign sts.k_zero     = (k_r == '0);
  assign sts.rd_later   = (rd_dl_r > deadline_r);
  assign sts.rd_due     = (rd_dl_r <= now_r);

  `SWTQ_ASSERT_NOW(a_count_range, clk, rst_n, 1'b1, count_r <= CW'(DEPTH))
  `SWTQ_ASSERT_NOW(a_pop_nonempty, clk, rst_n, cmd.pop, count_r != '0 && !cmd.wr_new)
  `SWTQ_ASSERT_NEXT(a_insert_grows, clk, rst_n, cmd.wr_new, count_r == $past(count_r) + 1'b1)

endmodule

FILE: design/sorted_wakeup_timer_queue.sv
// Top level of the sorted wakeup timer queue: register port and module wiring.
//
// A deadline queue kept in ascending wakeup order in a small memory.
// Input channel: an item is transferred at a rising edge with start high and
// busy low. A sleep request (req_type 0) gives requester_id, sleep_seconds and
// now_time; a clock tick (req_type 1) gives only now_time.
// Result channel: each result sits on out_data for exactly one cycle with
// out_strobe high; the receiver cannot stall, so none is ever held back.
// A sleep request gives one status result: rejects and zero counts come from
// the decide step, a queued request after the multiply, add and insertion
// steps, where the insertion moves each later entry up one slot with one
// memory read and one write. A clock tick pops due entries from the head and
// gives one wake notice for each; notices are paced by the registered read of
// the store, and the notice for a popped entry is issued at the following head
// compare, or in a final step when the tick empties the queue. A tick with
// nothing due gives no result. busy stays high until the last result is issued.
// The APB-style port holds ticks_per_second at byte address 0; write it only
// while busy is low. Reset empties the queue and restores ticks_per_second to
// its default; the store contents themselves are not cleared.
module sorted_wakeup_timer_queue #(
  parameter int QUEUE_DEPTH = swtq_pkg::DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  swtq_pkg::in_item_t  in_data,
  output logic                out_strobe,
  output swtq_pkg::out_item_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import swtq_pkg::*;

  logic [TPS_W-1:0] tps_r;
  ctrl_cmd_t        cmd;
  dp_status_t       sts;

  // Register index is paddr[2]; only index zero exists.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r <= TPS_RESET;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      tps_r <= pwdata[TPS_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : 32'(tps_r);

  swtq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  swtq_datapath #(
    .DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_data          (in_data),
    .ticks_per_second (tps_r),
    .cmd              (cmd),
    .sts              (sts),
    .out_strobe       (out_strobe),
    .out_data         (out_data)
  );

endmodule
